>>> rtl/core/jsu_pkg.sv
// ============================================================================
// jsu_pkg
// Shared types, codes and helpers of the JSON string unescape block.
// ============================================================================
package jsu_pkg;

    // Escape modes of the decoder.
    localparam logic [1:0] MODE_TEXT = 2'd0;
    localparam logic [1:0] MODE_ESC  = 2'd1;
    localparam logic [1:0] MODE_HEX  = 2'd2;

    // End-of-string status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TOO_LONG  = 2'd1;
    localparam logic [1:0] ST_BAD_ESC   = 2'd2;
    localparam logic [1:0] ST_TRUNCATED = 2'd3;

    // Result kinds.
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam int unsigned LEN_W = 13;
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 13'd128;

    // Maximum number of results caused by one input item.
    localparam int unsigned MAX_RES = 4;

    // Per-string decoder state.
    typedef struct packed {
        logic [1:0]       mode;
        logic [1:0]       hex_left;
        logic [15:0]      code_point;
        logic [LEN_W-1:0] out_count;
        logic [1:0]       err;
    } t_dec_state;

    // Group of results produced by one input item, in delivery order.
    typedef struct packed {
        logic [2:0]                count;
        logic [MAX_RES-1:0]        kind;
        logic [MAX_RES-1:0][7:0]   data;
        logic [MAX_RES-1:0][1:0]   status;
        logic [MAX_RES-1:0]        last;
    } t_pkt;

    // Hex digit check and value; bit 4 is set for a valid digit.
    function automatic logic [4:0] hex_nibble(input logic [7:0] b);
        logic [4:0] r;
        begin
            r = 5'd0;
            if (b >= 8'h30 && b <= 8'h39) begin
                r = {1'b1, b[3:0]};
            end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
                r = {1'b1, b[3:0] + 4'd9};
            end
            return r;
        end
    endfunction

endpackage

>>> rtl/core/json_string_unescape_top.sv
// ============================================================================
// json_string_unescape_top
// Streaming JSON string body unescaper with UTF-8 output of \u escapes.
// ============================================================================
// A request is held in the input register, then decoded into the result register.
// Throughput: one item per cycle while each item yields at most one result and the
// output is not stalled; an item's results hold the result register until taken.
// Reset: synchronous, active low; clears the decoder state and the valids,
// and sets max_out_len to 128.
module json_string_unescape_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [12:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_has_byte,
    input  logic        i_last_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_kind,
    output logic [7:0]  o_out_byte,
    output logic [1:0]  o_status,
    output logic        o_last
);

    logic                r_in_valid;
    logic [7:0]          r_in_byte;
    logic                r_has_byte;
    logic                r_last_in;
    logic [12:0]         r_max_out_len;
    jsu_pkg::t_dec_state r_state;
    jsu_pkg::t_dec_state n_state;
    jsu_pkg::t_pkt       n_pkt;
    logic                can_load;
    logic                fire;
    logic                accept;

    // Handshake: the held request is decoded once its results have room.
    assign fire       = r_in_valid && can_load;
    assign o_in_stall = r_in_valid && !can_load;
    assign accept     = i_in_valid && !o_in_stall;

    // Input register and configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_max_out_len <= jsu_pkg::MAX_LEN_RESET;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                r_max_out_len <= i_cfg_wr_data;
            end
        end
        if (accept) begin
            r_in_byte  <= i_in_byte;
            r_has_byte <= i_has_byte;
            r_last_in  <= i_last_in;
        end
    end

    // Decoder state advances once per decoded request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (fire) begin
            r_state <= n_state;
        end
    end

    jsu_decode u_decode (
        .i_state       (r_state),
        .i_max_out_len (r_max_out_len),
        .i_in_byte     (r_in_byte),
        .i_has_byte    (r_has_byte),
        .i_last_in     (r_last_in),
        .o_state       (n_state),
        .o_pkt         (n_pkt)
    );

    jsu_resq u_resq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (fire && n_pkt.count != 3'd0),
        .i_pkt      (n_pkt),
        .o_can_load (can_load),
        .o_valid    (o_out_valid),
        .i_stall    (i_out_stall),
        .o_kind     (o_kind),
        .o_out_byte (o_out_byte),
        .o_status   (o_status),
        .o_last     (o_last)
    );

endmodule

>>> rtl/core/jsu_decode.sv
// ============================================================================
// jsu_decode
// Combinational escape decoder: next state and result group for one item.
// ============================================================================
module jsu_decode (
    input  jsu_pkg::t_dec_state i_state,
    input  logic [12:0]         i_max_out_len,
    input  logic [7:0]          i_in_byte,
    input  logic                i_has_byte,
    input  logic                i_last_in,
    output jsu_pkg::t_dec_state o_state,
    output jsu_pkg::t_pkt       o_pkt
);

    jsu_pkg::t_dec_state s;
    logic [2:0][7:0]     buf_b;
    logic [1:0]          n_buf;
    logic [1:0]          n_emit;
    logic [4:0]          hv;
    logic [15:0]         cp;
    logic [13:0]         sum;

    assign hv = jsu_pkg::hex_nibble(i_in_byte);
    assign cp = {i_state.code_point[11:0], hv[3:0]};

    // Decode one byte, then apply the end-of-string handling.
    always_comb begin
        s      = i_state;
        buf_b  = '0;
        n_buf  = 2'd0;
        n_emit = 2'd0;
        sum    = '0;
        o_pkt  = '0;
        if (i_has_byte && i_state.err == jsu_pkg::ST_OK) begin
            unique case (i_state.mode)
                jsu_pkg::MODE_TEXT: begin
                    if (i_in_byte == 8'h5c) begin
                        s.mode = jsu_pkg::MODE_ESC;
                    end else begin
                        buf_b[0] = i_in_byte;
                        n_buf    = 2'd1;
                    end
                end
                jsu_pkg::MODE_ESC: begin
                    s.mode = jsu_pkg::MODE_TEXT;
                    unique case (i_in_byte)
                        8'h22, 8'h5c, 8'h2f: begin
                            buf_b[0] = i_in_byte;
                            n_buf    = 2'd1;
                        end
                        8'h62: begin buf_b[0] = 8'h08; n_buf = 2'd1; end
                        8'h66: begin buf_b[0] = 8'h0c; n_buf = 2'd1; end
                        8'h6e: begin buf_b[0] = 8'h0a; n_buf = 2'd1; end
                        8'h72: begin buf_b[0] = 8'h0d; n_buf = 2'd1; end
                        8'h74: begin buf_b[0] = 8'h09; n_buf = 2'd1; end
                        8'h75: begin
                            s.mode       = jsu_pkg::MODE_HEX;
                            s.hex_left   = 2'd3;
                            s.code_point = 16'd0;
                        end
                        default: begin
                            s.err = jsu_pkg::ST_BAD_ESC;
                        end
                    endcase
                end
                default: begin
                    // Hex digits of a \u escape; the fourth one emits UTF-8.
                    if (!hv[4]) begin
                        s.err = jsu_pkg::ST_BAD_ESC;
                    end else begin
                        s.code_point = cp;
                        if (i_state.hex_left != 2'd0) begin
                            s.hex_left = i_state.hex_left - 2'd1;
                        end else begin
                            s.mode = jsu_pkg::MODE_TEXT;
                            if (cp <= 16'h007f) begin
                                buf_b[0] = cp[7:0];
                                n_buf    = 2'd1;
                            end else if (cp <= 16'h07ff) begin
                                buf_b[0] = 8'hc0 | {3'd0, cp[10:6]};
                                buf_b[1] = 8'h80 | {2'd0, cp[5:0]};
                                n_buf    = 2'd2;
                            end else begin
                                buf_b[0] = 8'he0 | {4'd0, cp[15:12]};
                                buf_b[1] = 8'h80 | {2'd0, cp[11:6]};
                                buf_b[2] = 8'h80 | {2'd0, cp[5:0]};
                                n_buf    = 2'd3;
                            end
                        end
                    end
                end
            endcase

            // Capacity check: all bytes of the output or none of them.
            if (n_buf != 2'd0) begin
                sum = {1'b0, i_state.out_count} + {12'd0, n_buf};
                if (sum >= {1'b0, i_max_out_len}) begin
                    s.err = jsu_pkg::ST_TOO_LONG;
                end else begin
                    n_emit      = n_buf;
                    s.out_count = sum[12:0];
                    for (int k = 0; k < 3; k++) begin
                        o_pkt.data[k] = buf_b[k];
                    end
                end
            end
        end

        o_pkt.count = {1'b0, n_emit};
        // End of string: status result, then every state entry returns to zero.
        if (i_last_in) begin
            if (s.err == jsu_pkg::ST_OK && s.mode != jsu_pkg::MODE_TEXT) begin
                s.err = jsu_pkg::ST_TRUNCATED;
            end
            o_pkt.kind[n_emit]   = jsu_pkg::KIND_END;
            o_pkt.status[n_emit] = s.err;
            o_pkt.last[n_emit]   = 1'b1;
            o_pkt.count          = {1'b0, n_emit} + 3'd1;
            s                    = '0;
        end
        o_state = s;
    end

endmodule

>>> rtl/core/jsu_resq.sv
// ============================================================================
// jsu_resq
// Result register: delivers a held group one result a cycle while not stalled.
// ============================================================================
module jsu_resq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  jsu_pkg::t_pkt i_pkt,
    output logic          o_can_load,
    output logic          o_valid,
    input  logic          i_stall,
    output logic          o_kind,
    output logic [7:0]    o_out_byte,
    output logic [1:0]    o_status,
    output logic          o_last
);

    logic          r_valid;
    jsu_pkg::t_pkt r_pkt;
    logic [1:0]    r_idx;
    logic          take;
    logic          finish;

    // A group ends when its final result is taken.
    assign take       = r_valid && !i_stall;
    assign finish     = take && (({1'b0, r_idx} + 3'd1) == r_pkt.count);
    assign o_can_load = !r_valid || finish;

    // Group storage and read pointer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= 2'd0;
        end else if (finish) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_idx <= r_idx + 2'd1;
        end
        if (i_load) begin
            r_pkt <= i_pkt;
        end
    end

    // Current result.
    assign o_valid    = r_valid;
    assign o_kind     = r_pkt.kind[r_idx];
    assign o_out_byte = r_pkt.data[r_idx];
    assign o_status   = r_pkt.status[r_idx];
    assign o_last     = r_pkt.last[r_idx];

    // A group is loaded only into a free slot and never empty.
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (o_can_load && i_pkt.count != 3'd0 && i_pkt.count <= 3'd4))
        else $error("result group loaded into a busy slot or with bad count");

    // The read pointer stays within the held group.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> ({1'b0, r_idx} < r_pkt.count))
        else $error("result pointer beyond group");

    // An end result is always the final one of the string.
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && o_kind == jsu_pkg::KIND_END) |-> (o_last && finish == take))
        else $error("end result not final in group");

endmodule

>>> tb/sv/unescape_scoreboard_pkg.sv
`timescale 1ns / 100ps
// ============================================================================
// unescape_scoreboard_pkg
// Expected-result tracking for the JSON string unescape block. The class
// keeps its own copy of the decoder state and the output limit, turns every
// accepted request into the decoded bytes and end status it must cause, and
// checks the block's results against them in order.
// ============================================================================
package unescape_scoreboard_pkg;

    import jsu_pkg::*;

    // Bytes with a meaning of their own in the escaped text.
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_U      = 8'h75;

    // Value of a hex digit in either case, or -1 for any other byte.
    function automatic int nibble_of(logic [7:0] b);
        if (b >= "0" && b <= "9") begin
            return int'(b) - int'("0");
        end
        if (b >= "a" && b <= "f") begin
            return int'(b) - int'("a") + 10;
        end
        if (b >= "A" && b <= "F") begin
            return int'(b) - int'("A") + 10;
        end
        return -1;
    endfunction

    class unescape_scoreboard;

        typedef struct {
            logic       kind;
            logic [7:0] data;
            logic [1:0] status;
            logic       last;
        } t_decoded;

        // Decoded bytes and end results still owed by the block, oldest first.
        t_decoded decoded_q[$];

        // Mirror of the block's limit register and per-string state.
        logic [12:0] out_limit;
        logic [1:0]  mode;
        logic [1:0]  hex_left;
        logic [15:0] code_point;
        logic [12:0] out_count;
        logic [1:0]  err;

        int failures;
        int data_seen;
        int strings_seen;
        int status_seen[4];

        function new();
            out_limit    = MAX_LEN_RESET;
            failures     = 0;
            data_seen    = 0;
            strings_seen = 0;
            foreach (status_seen[i]) begin
                status_seen[i] = 0;
            end
            clear_string();
        endfunction

        function void clear_string();
            mode       = MODE_TEXT;
            hex_left   = 2'd0;
            code_point = 16'd0;
            out_count  = '0;
            err        = ST_OK;
        endfunction

        function void set_limit(logic [12:0] value);
            out_limit = value;
        endfunction

        // A decoded sequence goes out whole or not at all; one byte of the
        // buffer is always kept back for the terminator.
        function void queue_bytes(logic [7:0] seq[3], int n);
            t_decoded d;
            if (int'(out_count) + n >= int'(out_limit)) begin
                err = ST_TOO_LONG;
                return;
            end
            for (int i = 0; i < n; i++) begin
                d.kind   = KIND_DATA;
                d.data   = seq[i];
                d.status = ST_OK;
                d.last   = 1'b0;
                decoded_q.push_back(d);
            end
            out_count = out_count + 13'(n);
        endfunction

        // Advance the decoder by one raw byte of the string body.
        function void decode_byte(logic [7:0] b);
            logic [7:0] seq[3];
            int         n;
            int         v;
            n = 0;
            case (mode)
                MODE_TEXT: begin
                    if (b == CH_BSLASH) begin
                        mode = MODE_ESC;
                        return;
                    end
                    seq[0] = b;
                    n = 1;
                end
                MODE_ESC: begin
                    mode = MODE_TEXT;
                    n = 1;
                    case (b)
                        CH_QUOTE, CH_BSLASH, CH_SLASH: seq[0] = b;
                        "b": seq[0] = 8'h08;
                        "f": seq[0] = 8'h0c;
                        "n": seq[0] = 8'h0a;
                        "r": seq[0] = 8'h0d;
                        "t": seq[0] = 8'h09;
                        CH_U: begin
                            mode       = MODE_HEX;
                            hex_left   = 2'd3;
                            code_point = 16'd0;
                            return;
                        end
                        default: begin
                            err = ST_BAD_ESC;
                            return;
                        end
                    endcase
                end
                default: begin
                    v = nibble_of(b);
                    if (v < 0) begin
                        err = ST_BAD_ESC;
                        return;
                    end
                    code_point = {code_point[11:0], 4'(v)};
                    if (hex_left != 2'd0) begin
                        hex_left = hex_left - 2'd1;
                        return;
                    end
                    mode = MODE_TEXT;
                    // UTF-8 in one, two or three bytes; surrogates are
                    // encoded like any other value.
                    if (code_point <= 16'h007f) begin
                        seq[0] = code_point[7:0];
                        n = 1;
                    end else if (code_point <= 16'h07ff) begin
                        seq[0] = 8'hc0 | {3'b000, code_point[10:6]};
                        seq[1] = 8'h80 | {2'b00, code_point[5:0]};
                        n = 2;
                    end else begin
                        seq[0] = 8'he0 | {4'b0000, code_point[15:12]};
                        seq[1] = 8'h80 | {2'b00, code_point[11:6]};
                        seq[2] = 8'h80 | {2'b00, code_point[5:0]};
                        n = 3;
                    end
                end
            endcase
            queue_bytes(seq, n);
        endfunction

        // Note one accepted request and queue what it must produce.
        function void accept_request(logic [7:0] b, logic has, logic fin);
            t_decoded d;
            if (has && err == ST_OK) begin
                decode_byte(b);
            end
            if (fin) begin
                if (err == ST_OK && mode != MODE_TEXT) begin
                    err = ST_TRUNCATED;
                end
                d.kind   = KIND_END;
                d.data   = 8'h00;
                d.status = err;
                d.last   = 1'b1;
                decoded_q.push_back(d);
                clear_string();
            end
        endfunction

        function void compare_field(string name, logic [7:0] expv, logic [7:0] act);
            if (act !== expv) begin
                $error("%s mismatch: expected %0h, actual %0h", name, expv, act);
                failures++;
            end
        endfunction

        // Check one accepted result against the oldest expectation.
        function void check_decoded(logic kind, logic [7:0] data, logic [1:0] status,
                                    logic last);
            t_decoded e;
            if (decoded_q.size() == 0) begin
                $error("unexpected result: kind %0h byte %0h status %0h last %0h",
                       kind, data, status, last);
                failures++;
                return;
            end
            e = decoded_q.pop_front();
            compare_field("kind", 8'(e.kind), 8'(kind));
            compare_field("out_byte", e.data, data);
            compare_field("status", 8'(e.status), 8'(status));
            compare_field("last", 8'(e.last), 8'(last));
            if (e.kind == KIND_END) begin
                strings_seen++;
                status_seen[e.status]++;
            end else begin
                data_seen++;
            end
        endfunction

    endclass

endpackage

>>> tb/sv/json_string_unescape_top_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// json_string_unescape_top_tb
// Self-checking bench for the JSON string unescape block. It feeds string
// bodies made of plain text, simple escapes and \u escapes, with bad and cut
// off escapes mixed in, under several output limits, and checks every
// decoded byte and end status against its own decoder. The sender works in
// bursts and the receiver stalls, once for a long stretch.
// ============================================================================
module json_string_unescape_top_tb;

    import jsu_pkg::*;
    import unescape_scoreboard_pkg::*;

    typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN} t_stall_style;

    localparam logic [7:0] ESCAPE_LETTERS [8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH,
                                                   "b", "f", "n", "r", "t"};

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [12:0] i_cfg_wr_data = '0;
    logic        i_in_valid    = 1'b0;
    logic [7:0]  i_in_byte     = '0;
    logic        i_has_byte    = 1'b0;
    logic        i_last_in     = 1'b0;
    logic        i_out_stall   = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_kind;
    logic [7:0]  o_out_byte;
    logic [1:0]  o_status;
    logic        o_last;

    unescape_scoreboard sb;

    // Sender and receiver behavior, changed from phase to phase.
    t_stall_style stall_mode    = STALL_NONE;
    logic [15:0]  stall_pattern = 16'h0000;
    bit           bursty        = 1'b0;
    int           burst_left    = 0;
    int           request_count = 0;

    json_string_unescape_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_byte    (i_in_byte),
        .i_has_byte   (i_has_byte),
        .i_last_in    (i_last_in),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_kind       (o_kind),
        .o_out_byte   (o_out_byte),
        .o_status     (o_status),
        .o_last       (o_last)
    );

    // 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Check every result the block hands over.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_decoded(o_kind, o_out_byte, o_status, o_last);
        end
    end

    // Receiver: one long hold-off once the run is well under way, otherwise
    // the stall style of the current phase.
    initial begin : receiver
        int cyc;
        int hold_left;
        bit held;
        cyc       = 0;
        hold_left = 0;
        held      = 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (!held && request_count >= 200) begin
                held      = 1'b1;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                case (stall_mode)
                    STALL_NONE:   i_out_stall <= 1'b0;
                    STALL_RANDOM: i_out_stall <= ($urandom_range(0, 99) < 35);
                    default:      i_out_stall <= stall_pattern[cyc % 16];
                endcase
            end
        end
    end

    // Hard limit on the run time.
    initial begin
        #3000000;
        $display("simulation failed");
        $finish;
    end

    function automatic logic [7:0] hex_char(int v, bit upper);
        if (v < 10) begin
            return 8'("0" + v);
        end
        return 8'((upper ? "A" : "a") + v - 10);
    endfunction

    function automatic bit is_escape_letter(logic [7:0] b);
        foreach (ESCAPE_LETTERS[i]) begin
            if (b == ESCAPE_LETTERS[i]) begin
                return 1'b1;
            end
        end
        return b == CH_U;
    endfunction

    // Any byte except the backslash, so the text stays plain.
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == CH_BSLASH) begin
            b = 8'h5d;
        end
        return b;
    endfunction

    // Code points spread over the one, two and three byte encodings.
    function automatic logic [15:0] random_code_point();
        logic [15:0] edges [7];
        edges = '{16'h0000, 16'h007f, 16'h0080, 16'h07ff, 16'h0800, 16'hd800, 16'hffff};
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 16'h007f));
            1: return 16'($urandom_range(16'h0080, 16'h07ff));
            2: return 16'($urandom_range(16'h0800, 16'hffff));
            default: return edges[$urandom_range(0, 6)];
        endcase
    endfunction

    // Offer one request and hold it until the block takes it. A new burst
    // may start after an idle gap.
    task automatic send_request(logic [7:0] b, logic has, logic fin);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = bursty ? $urandom_range(1, 6) : 0;
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        i_has_byte <= has;
        i_last_in  <= fin;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.accept_request(b, has, fin);
        if (has || fin) begin
            request_count++;
        end
    endtask

    task automatic send_text(string s, bit fin);
        for (int i = 0; i < s.len(); i++) begin
            send_request(s[i], 1'b1, fin && i == s.len() - 1);
        end
    endtask

    task automatic send_escape(logic [7:0] letter, bit fin);
        send_request(CH_BSLASH, 1'b1, 1'b0);
        send_request(letter, 1'b1, fin);
    endtask

    task automatic send_unicode(logic [15:0] cp, bit fin);
        send_request(CH_BSLASH, 1'b1, 1'b0);
        send_request(CH_U, 1'b1, 1'b0);
        for (int k = 3; k >= 0; k--) begin
            send_request(hex_char(int'((cp >> (4 * k)) & 16'hf), 1'($urandom_range(0, 1))),
                         1'b1, fin && k == 0);
        end
    endtask

    // Backslash, 'u' and up to three good digits; the final request is
    // either a bad digit or the end of the body.
    task automatic send_partial_unicode(int good, bit bad_tail, bit fin);
        logic [7:0] b;
        send_request(CH_BSLASH, 1'b1, 1'b0);
        send_request(CH_U, 1'b1, fin && good == 0 && !bad_tail);
        for (int j = 0; j < good; j++) begin
            send_request(hex_char($urandom_range(0, 15), 1'($urandom_range(0, 1))), 1'b1,
                         fin && j == good - 1 && !bad_tail);
        end
        if (bad_tail) begin
            do b = 8'($urandom_range(0, 255)); while (nibble_of(b) >= 0);
            send_request(b, 1'b1, fin);
        end
    endtask

    // One string body: mostly well-formed escapes and text, with empty
    // requests, bad escapes and cut off endings mixed in.
    task automatic send_random_string();
        int         tokens;
        int         sel;
        logic [7:0] b;
        tokens = $urandom_range(0, 8);
        if ($urandom_range(0, 9) == 0) begin
            tokens = $urandom_range(10, 30);
        end
        for (int t = 0; t < tokens; t++) begin
            sel = $urandom_range(0, 99);
            if (sel < 5) begin
                send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            end else if (sel < 47) begin
                send_request(plain_byte(), 1'b1, 1'b0);
            end else if (sel < 70) begin
                send_escape(ESCAPE_LETTERS[$urandom_range(0, 7)], 1'b0);
            end else if (sel < 94) begin
                send_unicode(random_code_point(), 1'b0);
            end else if (sel < 97) begin
                do b = 8'($urandom_range(0, 255)); while (is_escape_letter(b));
                send_escape(b, 1'b0);
            end else begin
                send_partial_unicode($urandom_range(0, 3), 1'b1, 1'b0);
            end
        end
        // The end of the body rides on its own request or on the last token.
        sel = $urandom_range(0, 18);
        if (sel < 5) begin
            send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        end else if (sel < 12) begin
            send_request(plain_byte(), 1'b1, 1'b1);
        end else if (sel < 15) begin
            send_escape(ESCAPE_LETTERS[$urandom_range(0, 7)], 1'b1);
        end else if (sel < 17) begin
            send_unicode(random_code_point(), 1'b1);
        end else if (sel < 18) begin
            send_request(CH_BSLASH, 1'b1, 1'b1);
        end else begin
            send_partial_unicode($urandom_range(0, 3), 1'b0, 1'b1);
        end
    endtask

    // Stop offering requests and wait for every owed result, then let the
    // pipeline settle.
    task automatic drain(int settle);
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (sb.decoded_q.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // The limit register is only written with the block idle.
    task automatic write_limit(logic [12:0] value);
        drain(6);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.set_limit(value);
    endtask

    // Main sequence: reset, directed strings, then random phases.
    initial begin : stimulus
        logic [12:0] phase_limit [10];
        int          phase_end;
        sb = new();
        phase_limit = '{13'd128, 13'd4096, 13'd1, 13'd6, 13'd0, 13'd17, 13'd4095,
                        13'd2, 13'd40, 13'd9};
        phase_limit[9] = 13'($urandom_range(3, 64));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed strings with a free-running sender and receiver.
        write_limit(MAX_LEN_RESET);
        send_text("\\uFfFf", 1'b1);
        send_text("\\u07fF", 1'b0);
        send_request(8'h00, 1'b0, 1'b1);
        send_request(8'h00, 1'b1, 1'b0);
        send_request(8'hff, 1'b1, 1'b1);
        send_text("\\q", 1'b1);
        send_text("\\u0g", 1'b1);
        send_request(8'h5a, 1'b0, 1'b0);
        send_text("\\", 1'b1);
        send_text("\\\"\\/\\t", 1'b1);

        // No room at all, then a three byte sequence that just fits.
        write_limit(13'd1);
        send_text("a", 1'b1);
        write_limit(13'd4);
        send_text("\\u0800b", 1'b1);

        // Random strings under a different limit and idle pattern per phase.
        for (int p = 0; p < 10; p++) begin
            write_limit(phase_limit[p]);
            stall_mode    = t_stall_style'(p % 3);
            bursty        = (p % 4 != 0);
            stall_pattern = 16'($urandom);
            phase_end     = request_count + 26;
            while (request_count < phase_end) begin
                send_random_string();
            end
        end
        drain(8);

        $display("Decoded %0d bytes and %0d string ends from %0d requests, limits 0 to 4096.",
                 sb.data_seen, sb.strings_seen, request_count);
        $display("End status: ok %0d, too long %0d, bad escape %0d, truncated %0d.",
                 sb.status_seen[ST_OK], sb.status_seen[ST_TOO_LONG],
                 sb.status_seen[ST_BAD_ESC], sb.status_seen[ST_TRUNCATED]);
        if (sb.failures == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/jsu_pkg.sv
rtl/core/jsu_decode.sv
rtl/core/jsu_resq.sv
rtl/core/json_string_unescape_top.sv
tb/sv/unescape_scoreboard_pkg.sv
tb/sv/json_string_unescape_top_tb.sv
